// ===== design/fsod_pkg.sv =====
// Shared types and constants for the front sector obstacle decider.
// Used by fsod_angle_unit and front_sector_obstacle_decider_unit; no dependencies.
package fsod_pkg;

    // Range storage width default; ranges travel as 16-bit fields on the ports
    localparam int RANGE_BITS_DEF = 16;

    localparam int FIELD_W  = 16;  // range, speed and register field width
    localparam int START_W  = 17;  // header start angle
    localparam int STEP_W   = 14;  // header angle step
    localparam int ANGLE_W  = 32;  // accumulated sample angle
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;

    // Input item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TICK   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    // Command kinds carried in the result tuser
    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_TURN    = 2'd1,
        MODE_NO_SCAN = 2'd2,
        MODE_TIMEOUT = 2'd3
    } t_drive_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAFE_DISTANCE    = 3'd0,
        CFG_CRUISE_SPEED     = 3'd1,
        CFG_SPIN_RATE        = 3'd2,
        CFG_HALF_SECTOR      = 3'd3,
        CFG_FALLBACK_ENABLE  = 3'd4,
        CFG_STALE_TICKS      = 3'd5,
        CFG_FALLBACK_LINEAR  = 3'd6,
        CFG_FALLBACK_ANGULAR = 3'd7
    } t_cfg_idx;

    // Register reset values
    localparam logic [FIELD_W-1:0] SAFE_DISTANCE_RST    = 16'd600;
    localparam logic [FIELD_W-1:0] CRUISE_SPEED_RST     = 16'd200;
    localparam logic [FIELD_W-1:0] SPIN_RATE_RST        = 16'd600;
    localparam logic [FIELD_W-1:0] HALF_SECTOR_RST      = 16'd8579;
    localparam logic               FALLBACK_ENABLE_RST  = 1'b1;
    localparam logic [FIELD_W-1:0] STALE_TICKS_RST      = 16'd15;
    localparam logic [FIELD_W-1:0] FALLBACK_LINEAR_RST  = 16'd100;
    localparam logic [FIELD_W-1:0] FALLBACK_ANGULAR_RST = 16'd0;

    // Result of the per-sample angle check
    typedef struct packed {
        logic               in_sector;
        logic [ANGLE_W-1:0] next_angle;
    } t_angle_res;

endpackage

// ===== design/fsod_angle_unit.sv =====
// Sector test and saturating angle advance for one range sample.
// Depends on fsod_pkg.
module fsod_angle_unit
    import fsod_pkg::*;
(
    input  logic signed [ANGLE_W-1:0] i_angle,
    input  logic signed [STEP_W-1:0]  i_step,
    input  logic        [FIELD_W-1:0] i_half_sector,
    output t_angle_res                o_res
);
    localparam int EXT_W = ANGLE_W + 1;

    logic signed [EXT_W-1:0] angle_ext;
    logic signed [EXT_W-1:0] half_ext;
    logic signed [EXT_W-1:0] sum;
    logic signed [EXT_W-1:0] max_ext;
    logic signed [EXT_W-1:0] min_ext;
    logic                    in_sector;
    logic [ANGLE_W-1:0]      next_angle;

    assign angle_ext = EXT_W'(i_angle);
    assign half_ext  = $signed({{(EXT_W-FIELD_W){1'b0}}, i_half_sector});
    assign max_ext   = $signed({2'b00, {(ANGLE_W-1){1'b1}}});
    assign min_ext   = $signed({2'b11, {(ANGLE_W-1){1'b0}}});

    // |angle| <= half  <=>  -half <= angle <= half
    assign in_sector = (angle_ext <= half_ext) && (angle_ext >= -half_ext);

    // Advance by one step, clamped to the signed 32-bit range
    assign sum = angle_ext + EXT_W'(i_step);

    always_comb begin
        if (sum > max_ext) begin
            next_angle = max_ext[ANGLE_W-1:0];
        end else if (sum < min_ext) begin
            next_angle = min_ext[ANGLE_W-1:0];
        end else begin
            next_angle = sum[ANGLE_W-1:0];
        end
    end

    assign o_res = '{in_sector: in_sector, next_angle: next_angle};

endmodule

// ===== design/front_sector_obstacle_decider_unit.sv =====
// Front sector obstacle decider: scan header, range samples and command ticks in,
// drive commands out. Depends on fsod_pkg and fsod_angle_unit.
//
// Usage: items enter on the s_ stream, one per cycle at full rate; tuser holds the
// item kind (header, sample, tick) and tlast marks a scan's final sample. Each item
// is held in the input register and resolved from there against the scan state, its
// command going into the result register; throughput is one item per cycle and the
// only thing that holds the input back is a full result register waiting on
// m_tready. Only ticks produce a command. Range state is RANGE_BITS wide and
// nearest_front reports the committed minimum clamped to 65535. Configuration
// writes take effect on the next cycle and should only occur while the block is idle.
module front_sector_obstacle_decider_unit
    import fsod_pkg::*;
#(
    parameter int RANGE_BITS = RANGE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata, low bit up: start_angle[17], angle_step[14], range_floor[16],
    // range_ceiling[16], range_mm[16], range_invalid[1]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,   // opcode[2]
    input  logic                  s_tlast,   // last_sample
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata, low bit up: linear_speed[16], angular_speed[16], nearest_front[16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]            m_tuser,   // drive_mode[2]
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [FIELD_W-1:0]    i_cfg_data
);
    localparam int RB    = RANGE_BITS;
    localparam int CMP_W = 33;

    // ---------------- configuration registers ----------------
    logic [FIELD_W-1:0] r_safe_distance, r_cruise_speed, r_spin_rate, r_half_sector;
    logic [FIELD_W-1:0] r_stale_ticks, r_fallback_linear, r_fallback_angular;
    logic               r_fallback_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_distance    <= SAFE_DISTANCE_RST;
            r_cruise_speed     <= CRUISE_SPEED_RST;
            r_spin_rate        <= SPIN_RATE_RST;
            r_half_sector      <= HALF_SECTOR_RST;
            r_fallback_enable  <= FALLBACK_ENABLE_RST;
            r_stale_ticks      <= STALE_TICKS_RST;
            r_fallback_linear  <= FALLBACK_LINEAR_RST;
            r_fallback_angular <= FALLBACK_ANGULAR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAFE_DISTANCE:    r_safe_distance    <= i_cfg_data;
                CFG_CRUISE_SPEED:     r_cruise_speed     <= i_cfg_data;
                CFG_SPIN_RATE:        r_spin_rate        <= i_cfg_data;
                CFG_HALF_SECTOR:      r_half_sector      <= i_cfg_data;
                CFG_FALLBACK_ENABLE:  r_fallback_enable  <= i_cfg_data[0];
                CFG_STALE_TICKS:      r_stale_ticks      <= i_cfg_data;
                CFG_FALLBACK_LINEAR:  r_fallback_linear  <= i_cfg_data;
                CFG_FALLBACK_ANGULAR: r_fallback_angular <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                r_in_valid;
    t_opcode             r_in_op;
    logic                r_in_last;
    logic [IN_DATA_W-1:0] r_in_data;
    logic                r_out_valid;
    logic                advance;
    logic                proc;

    // The resolve stage moves when the result register is free or being drained
    assign advance  = !r_out_valid || m_tready;
    assign s_tready = !r_in_valid || advance;
    assign proc     = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_op   <= t_opcode'(s_tuser);
            r_in_last <= s_tlast;
            r_in_data <= s_tdata;
        end
    end

    // Field unpacking
    logic signed [START_W-1:0] in_start;
    logic signed [STEP_W-1:0]  in_step;
    logic [RB-1:0]             in_floor, in_ceiling, in_range;
    logic                      in_invalid;
    logic [31:0]               floor_ext, ceil_ext, range_ext;

    assign in_start   = r_in_data[16:0];
    assign in_step    = r_in_data[30:17];
    assign floor_ext  = {16'b0, r_in_data[46:31]};
    assign ceil_ext   = {16'b0, r_in_data[62:47]};
    assign range_ext  = {16'b0, r_in_data[78:63]};
    assign in_invalid = r_in_data[79];
    assign in_floor   = floor_ext[RB-1:0];
    assign in_ceiling = ceil_ext[RB-1:0];
    assign in_range   = range_ext[RB-1:0];

    // ---------------- scan state ----------------
    logic [RB-1:0]             r_running_min, r_committed_min, r_scan_floor, r_scan_ceiling;
    logic signed [ANGLE_W-1:0] r_sample_angle;
    logic signed [STEP_W-1:0]  r_scan_step;
    logic                      r_have_scan;
    logic [FIELD_W-1:0]        r_ticks;

    t_angle_res angle_res;

    fsod_angle_unit u_angle (
        .i_angle       (r_sample_angle),
        .i_step        (r_scan_step),
        .i_half_sector (r_half_sector),
        .o_res         (angle_res)
    );

    // Sample qualification and minimum update
    logic          sample_hit;
    logic [RB-1:0] sample_min;

    assign sample_hit = angle_res.in_sector && !in_invalid &&
                        (in_range >= r_scan_floor) && (in_range <= r_scan_ceiling) &&
                        (in_range < r_running_min);
    assign sample_min = sample_hit ? in_range : r_running_min;

    // Saturating tick count as seen by this tick
    logic [FIELD_W-1:0] n_ticks;
    assign n_ticks = (r_ticks != '1) ? (r_ticks + 1'b1) : r_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_min   <= '1;
            r_committed_min <= '1;
            r_sample_angle  <= '0;
            r_scan_step     <= '0;
            r_scan_floor    <= '0;
            r_scan_ceiling  <= '0;
            r_have_scan     <= 1'b0;
            r_ticks         <= '0;
        end else if (proc) begin
            unique case (r_in_op)
                OP_HEADER: begin
                    r_sample_angle <= ANGLE_W'(in_start);
                    r_scan_step    <= in_step;
                    r_scan_floor   <= in_floor;
                    r_scan_ceiling <= in_ceiling;
                    r_running_min  <= '1;
                end
                OP_SAMPLE: begin
                    r_sample_angle <= angle_res.next_angle;
                    if (r_in_last) begin
                        r_committed_min <= sample_min;
                        r_have_scan     <= 1'b1;
                        r_ticks         <= '0;
                        r_running_min   <= '1;
                    end else begin
                        r_running_min <= sample_min;
                    end
                end
                OP_TICK: begin
                    if (r_have_scan) begin
                        r_ticks <= n_ticks;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- command decision ----------------
    logic [CMP_W-1:0]   committed_ext, safe_ext;
    logic [FIELD_W-1:0] nearest;
    logic               timeout;
    logic               n_out_valid;
    logic [FIELD_W-1:0] n_lin, n_ang;
    t_drive_mode        n_mode;

    assign committed_ext = {{(CMP_W-RB){1'b0}}, r_committed_min};
    assign safe_ext      = {{(CMP_W-FIELD_W){1'b0}}, r_safe_distance};
    assign nearest       = (committed_ext > CMP_W'(17'h0FFFF)) ? '1
                                                               : committed_ext[FIELD_W-1:0];
    assign timeout       = r_fallback_enable && (r_stale_ticks != '0) &&
                           (n_ticks > r_stale_ticks);

    always_comb begin
        n_out_valid = 1'b0;
        n_lin       = r_fallback_linear;
        n_ang       = r_fallback_angular;
        n_mode      = MODE_NO_SCAN;
        if (r_in_op == OP_TICK) begin
            priority if (!r_have_scan) begin
                n_out_valid = r_fallback_enable;
            end else if (timeout) begin
                n_out_valid = 1'b1;
                n_mode      = MODE_TIMEOUT;
            end else if (committed_ext < safe_ext) begin
                n_out_valid = 1'b1;
                n_lin       = '0;
                n_ang       = r_spin_rate;
                n_mode      = MODE_TURN;
            end else begin
                n_out_valid = 1'b1;
                n_lin       = r_cruise_speed;
                n_ang       = '0;
                n_mode      = MODE_FORWARD;
            end
        end
    end

    // ---------------- result register ----------------
    logic [OUT_DATA_W-1:0] r_out_data;
    t_drive_mode           r_out_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= proc && n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_out_valid) begin
            r_out_data <= {nearest, n_ang, n_lin};
            r_out_mode <= n_mode;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_mode;

    // ---------------- assertions ----------------
    // A new command only appears after a tick was resolved
    a_out_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(proc && r_in_op == OP_TICK))
        else $error("command appeared without a tick");

    // Once a scan has completed the block never forgets it
    a_have_scan_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_scan |=> r_have_scan)
        else $error("have_scan cleared after a completed scan");

    // A non-final sample can only lower the running minimum
    a_min_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_op == OP_SAMPLE && !r_in_last) |=>
        (r_running_min <= $past(r_running_min)))
        else $error("running minimum rose within a scan");

    // Turn commands only when the committed minimum is under the safe distance
    a_turn_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && n_out_valid && n_mode == MODE_TURN) |-> (committed_ext < safe_ext))
        else $error("turn issued with clear front");

endmodule

// ===== test/front_sector_obstacle_decider_unit_test.sv =====
// Self-checking testbench for front_sector_obstacle_decider_unit: directed scans and ticks,
// then randomized scan traffic under several register settings and handshake pressures.
// Depends on fsod_pkg and the front_sector_obstacle_decider_unit RTL.
`timescale 1ns / 1ps

module front_sector_obstacle_decider_unit_test;
    import fsod_pkg::*;

    localparam longint ANGLE_HIGH = 64'sd2147483647;
    localparam longint ANGLE_LOW  = -64'sd2147483648;
    localparam int PHASE_ITEMS = 360;
    localparam logic [FIELD_W-1:0] DEFAULT_CFG [8] = '{
        SAFE_DISTANCE_RST, CRUISE_SPEED_RST, SPIN_RATE_RST, HALF_SECTOR_RST,
        {15'd0, FALLBACK_ENABLE_RST}, STALE_TICKS_RST, FALLBACK_LINEAR_RST,
        FALLBACK_ANGULAR_RST
    };

    // One input item, all fields kept whatever the kind
    typedef struct packed {
        t_opcode            op;
        logic signed [16:0] start;
        logic signed [13:0] step;
        logic [15:0]        floor_mm;
        logic [15:0]        ceil_mm;
        logic [15:0]        range_mm;
        logic               invalid;
        logic               last;
    } t_scan_item;

    // One drive command
    typedef struct packed {
        logic [15:0] lin;
        logic [15:0] ang;
        t_drive_mode mode;
        logic [15:0] nearest;
    } t_drive_cmd;

    // Directed row: item, repeat count, optional hand-typed command
    typedef struct packed {
        t_scan_item  it;
        logic [15:0] reps;
        logic        typed;
        t_drive_cmd  want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // start_angle, angle_step, range_floor,
                                           // range_ceiling, range_mm, range_invalid
    logic [1:0]            s_tuser = '0;   // opcode
    logic                  s_tlast = 1'b0; // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;        // linear_speed, angular_speed, nearest_front
    logic [1:0]            m_tuser;        // drive_mode
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [FIELD_W-1:0]    i_cfg_data = '0;

    // Scan state mirror
    logic [15:0] near_run = 16'hFFFF;
    logic [15:0] near_held = 16'hFFFF;
    longint      sweep_angle = 0;
    longint      sweep_step = 0;
    logic [15:0] win_floor = '0;
    logic [15:0] win_ceil = '0;
    bit          scan_done = 1'b0;
    logic [15:0] tick_age = '0;

    // Register mirror
    logic [15:0] safe_mm = SAFE_DISTANCE_RST;
    logic [15:0] cruise_v = CRUISE_SPEED_RST;
    logic [15:0] spin_v = SPIN_RATE_RST;
    logic [15:0] half_sector = HALF_SECTOR_RST;
    bit          fb_on = FALLBACK_ENABLE_RST;
    logic [15:0] stale_limit = STALE_TICKS_RST;
    logic [15:0] fb_lin = FALLBACK_LINEAR_RST;
    logic [15:0] fb_ang = FALLBACK_ANGULAR_RST;

    t_drive_cmd pending_cmds[$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    bit         typed_on = 1'b0;
    t_drive_cmd typed_want = '0;

    front_sector_obstacle_decider_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Advance the mirror by one item; returns 1 when a command comes out
    function automatic bit predict_drive_command(input t_scan_item it, output t_drive_cmd cmd);
        longint mag;
        longint nxt;
        cmd = '0;
        case (it.op)
            OP_HEADER: begin
                sweep_angle = longint'(it.start);
                sweep_step = longint'(it.step);
                win_floor = it.floor_mm;
                win_ceil = it.ceil_mm;
                near_run = 16'hFFFF;
                return 1'b0;
            end
            OP_SAMPLE: begin
                mag = (sweep_angle < 0) ? -sweep_angle : sweep_angle;
                if (mag <= longint'(half_sector) && !it.invalid && it.range_mm >= win_floor &&
                    it.range_mm <= win_ceil && it.range_mm < near_run)
                    near_run = it.range_mm;
                // accumulated angle saturates at the signed 32-bit limits
                nxt = sweep_angle + sweep_step;
                if (nxt > ANGLE_HIGH) nxt = ANGLE_HIGH;
                if (nxt < ANGLE_LOW) nxt = ANGLE_LOW;
                sweep_angle = nxt;
                if (it.last) begin
                    near_held = near_run;
                    scan_done = 1'b1;
                    tick_age = '0;
                    near_run = 16'hFFFF;
                end
                return 1'b0;
            end
            OP_TICK: begin
                if (!scan_done) begin
                    cmd = '{fb_lin, fb_ang, MODE_NO_SCAN, near_held};
                    return fb_on;
                end
                if (tick_age != 16'hFFFF) tick_age++;
                if (fb_on && stale_limit != 0 && tick_age > stale_limit)
                    cmd = '{fb_lin, fb_ang, MODE_TIMEOUT, near_held};
                else if (near_held < safe_mm)
                    cmd = '{16'd0, spin_v, MODE_TURN, near_held};
                else
                    cmd = '{cruise_v, 16'd0, MODE_FORWARD, near_held};
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Input transfers feed the mirror and the queue of expected commands
    always @(posedge i_clk) begin : track_input
        t_scan_item it;
        t_drive_cmd cmd;
        bit         made;
        if (i_rst_n && s_tvalid && s_tready) begin
            it.op = t_opcode'(s_tuser);
            it.start = s_tdata[16:0];
            it.step = s_tdata[30:17];
            it.floor_mm = s_tdata[46:31];
            it.ceil_mm = s_tdata[62:47];
            it.range_mm = s_tdata[78:63];
            it.invalid = s_tdata[79];
            it.last = s_tlast;
            made = predict_drive_command(it, cmd);
            if (typed_on)
                pending_cmds.push_back(typed_want);
            else if (made)
                pending_cmds.push_back(cmd);
        end
    end

    // Result transfers against the oldest expectation
    always @(posedge i_clk) begin : check_output
        t_drive_cmd got;
        t_drive_cmd want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], t_drive_mode'(m_tuser), m_tdata[47:32]};
            if (pending_cmds.size() == 0) begin
                flag_mismatch("command with nothing expected");
            end else begin
                want = pending_cmds.pop_front();
                if (got.lin != want.lin)
                    flag_mismatch($sformatf("linear_speed %0d, expected %0d",
                                            $signed(got.lin), $signed(want.lin)));
                if (got.ang != want.ang)
                    flag_mismatch($sformatf("angular_speed %0d, expected %0d",
                                            $signed(got.ang), $signed(want.ang)));
                if (got.mode != want.mode)
                    flag_mismatch($sformatf("drive_mode %0d, expected %0d",
                                            got.mode, want.mode));
                if (got.nearest != want.nearest)
                    flag_mismatch($sformatf("nearest_front %0d, expected %0d",
                                            got.nearest, want.nearest));
            end
        end
    end

    function automatic t_scan_item mk_item(input t_opcode op, input int start, input int step,
                                           input int floor_mm, input int ceil_mm,
                                           input int range_mm, input int invalid,
                                           input int last);
        t_scan_item it;
        it.op = op;
        it.start = 17'(start);
        it.step = 14'(step);
        it.floor_mm = 16'(floor_mm);
        it.ceil_mm = 16'(ceil_mm);
        it.range_mm = 16'(range_mm);
        it.invalid = 1'(invalid);
        it.last = 1'(last);
        return it;
    endfunction

    // Every field random; the fields that the kind ignores stay as noise
    function automatic t_scan_item noise_item(input t_opcode op);
        return mk_item(op, $urandom_range(102944) - 51472, $urandom_range(16383),
                       $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                       $urandom_range(1), $urandom_range(1));
    endfunction

    // Sample with its range steered near the thresholds that matter
    function automatic t_scan_item sample_item(input bit last);
        t_scan_item it;
        it = noise_item(OP_SAMPLE);
        it.last = last;
        it.invalid = ($urandom_range(6) == 0);
        case ($urandom_range(3))
            0: ;
            1: it.range_mm = 16'(safe_mm + $urandom_range(64) - 32);
            2: it.range_mm = 16'($urandom_range(2047));
            default: it.range_mm = 16'(($urandom_range(1) ? win_floor : win_ceil)
                                       + $urandom_range(2) - 1);
        endcase
        return it;
    endfunction

    // One transfer on the input stream, with random sender gaps
    task automatic push_item(input t_scan_item it, input bit typed = 1'b0,
                             input t_drive_cmd want = '0);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {it.invalid, it.range_mm, it.ceil_mm, it.floor_mm, it.step, it.start};
        s_tuser <= it.op;
        s_tlast <= it.last;
        typed_on = typed;
        typed_want = want;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (it.op != OP_UNUSED) items_sent++;
    endtask

    // Stop sending, wait out every command and the pipeline behind it
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all eight registers back to back, block idle
    task automatic load_settings(input logic [15:0] vals [8]);
        t_cfg_idx idx;
        for (int i = 0; i < 8; i++) begin
            idx = t_cfg_idx'(i);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_data <= vals[i];
            case (idx)
                CFG_SAFE_DISTANCE:    safe_mm = vals[i];
                CFG_CRUISE_SPEED:     cruise_v = vals[i];
                CFG_SPIN_RATE:        spin_v = vals[i];
                CFG_HALF_SECTOR:      half_sector = vals[i];
                CFG_FALLBACK_ENABLE:  fb_on = vals[i][0];
                CFG_STALE_TICKS:      stale_limit = vals[i];
                CFG_FALLBACK_LINEAR:  fb_lin = vals[i];
                CFG_FALLBACK_ANGULAR: fb_ang = vals[i];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly complete scans with ticks around them, plus strays and noise
    task automatic run_traffic(input int target);
        t_scan_item it;
        int         pick;
        int         n;
        items_sent = 0;
        while (items_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                it = noise_item(OP_HEADER);
                if ($urandom_range(1)) begin
                    it.start = 17'($urandom_range(18000) - 9000);
                    it.step = 14'($urandom_range(3000) - 1500);
                end
                if ($urandom_range(4) != 0) begin
                    it.floor_mm = 16'($urandom_range(300));
                    it.ceil_mm = 16'(16'hFFFF - $urandom_range(3000));
                end
                push_item(it);
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(9) == 0) push_item(noise_item(OP_TICK));
                    push_item(sample_item(i == n - 1));
                end
                repeat ($urandom_range(1, 3)) push_item(noise_item(OP_TICK));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 20)) push_item(noise_item(OP_TICK));
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 4)) push_item(sample_item($urandom_range(1) != 0));
            end else if (pick < 95) begin
                push_item(noise_item(OP_HEADER));
            end else begin
                push_item(noise_item(OP_UNUSED));
            end
        end
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        t_plan_row   script[$];
        logic [15:0] cfg_vals [8];
        t_drive_cmd  none;
        none = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fallback off before any scan: ticks and unused items stay silent
        cfg_vals = DEFAULT_CFG;
        cfg_vals[CFG_FALLBACK_ENABLE] = 16'd0;
        load_settings(cfg_vals);
        push_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        push_item(mk_item(OP_UNUSED, 0, 0, 0, 0, 0, 0, 0));
        settle();
        load_settings(DEFAULT_CFG);

        // Directed scans at reset settings
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd100, 16'd0, MODE_NO_SCAN, 16'hFFFF}});
        script.push_back('{mk_item(OP_UNUSED, -1, -1, 65535, 65535, 65535, 1, 1), 16'd1,
                           1'b0, none});
        // samples before any header use the all-zero window at angle zero
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 65535, 1, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd0, 16'd600, MODE_TURN, 16'd0}});
        // widest start and step sweeping through the sector
        script.push_back('{mk_item(OP_HEADER, 51472, -8192, 0, 65535, 0, 0, 0), 16'd1,
                           1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 65535, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 300, 1, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 1, 0, 0), 16'd6, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 65535, 0, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b0, none});
        // range window edges, all samples at angle zero
        script.push_back('{mk_item(OP_HEADER, 0, 0, 100, 200, 0, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 99, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 201, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 200, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 100, 0, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd0, 16'd600, MODE_TURN, 16'd100}});
        // empty window: no sample qualifies, so the block drives forward
        script.push_back('{mk_item(OP_HEADER, 0, 0, 65535, 0, 0, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd200, 16'd0, MODE_FORWARD, 16'hFFFF}});
        // negative sector edge, then ticks up to the stale timeout
        script.push_back('{mk_item(OP_HEADER, -8580, 1, 0, 65535, 0, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 5, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 650, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 7, 1, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd200, 16'd0, MODE_FORWARD, 16'd650}});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd14, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd100, 16'd0, MODE_TIMEOUT, 16'd650}});
        // positive sector edge
        script.push_back('{mk_item(OP_HEADER, 8579, 1, 0, 65535, 0, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 640, 0, 0), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_SAMPLE, 0, 0, 0, 0, 3, 0, 1), 16'd1, 1'b0, none});
        script.push_back('{mk_item(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 16'd1, 1'b1,
                           '{16'd200, 16'd0, MODE_FORWARD, 16'd640}});
        foreach (script[r])
            repeat (script[r].reps) push_item(script[r].it, script[r].typed, script[r].want);
        settle();

        // Random phases over register settings and handshake pressure
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    cfg_vals = DEFAULT_CFG;
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    cfg_vals = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'd51472, 16'd1, 16'hFFFF,
                                 16'h7FFF, 16'h8000};
                    gap_pct = 60;
                    stall_pct = 0;
                end
                2: begin
                    cfg_vals = '{16'd0, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0,
                                 16'h8000, 16'h7FFF};
                    gap_pct = 0;
                    stall_pct = 60;
                end
                default: begin
                    cfg_vals = '{16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(51472)),
                                 16'($urandom_range(1)), 16'($urandom_range(40)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535))};
                    if (p == 3) begin
                        // short timeout, both sides idling a little
                        cfg_vals[CFG_FALLBACK_ENABLE] = 16'd1;
                        cfg_vals[CFG_STALE_TICKS] = 16'($urandom_range(1, 6));
                        gap_pct = 7;
                        stall_pct = 7;
                    end else begin
                        gap_pct = 0;
                        stall_pct = 0;
                    end
                end
            endcase
            load_settings(cfg_vals);
            run_traffic(PHASE_ITEMS);
            settle();
        end

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fsod_pkg.sv
design/fsod_angle_unit.sv
design/front_sector_obstacle_decider_unit.sv
test/front_sector_obstacle_decider_unit_test.sv
